### design/vfcm_pkg.sv
// Shared types and constants for the voxel face-cull mesher.
package vfcm_pkg;

	localparam int VERTEX_W = 17;
	localparam int KIND_W = 8;
	localparam int FACE_N = 6;
	localparam int COUNT_W = 3;

	// Face mask bit positions
	localparam int FACE_FRONT = 0;
	localparam int FACE_DOWN = 1;
	localparam int FACE_BACK = 2;
	localparam int FACE_UP = 3;
	localparam int FACE_LEFT = 4;
	localparam int FACE_RIGHT = 5;

	typedef enum logic [1:0] {
		FN_WRITE = 2'd0,
		FN_BEGIN = 2'd1,
		FN_MESH = 2'd2,
		FN_NONE = 2'd3
	} func_t;

	// Which occupancy row a read targets
	typedef enum logic [2:0] {
		RS_SELF = 3'd0,
		RS_DOWN = 3'd1,
		RS_UP = 3'd2,
		RS_LEFT = 3'd3,
		RS_RIGHT = 3'd4
	} rsel_t;

	typedef struct packed {
		logic  latch;
		logic  rd_en;
		rsel_t rd_sel;
		logic  cap_en;
		rsel_t cap_sel;
		logic  wr_en;
		logic  clr_en;
		logic  cnt_clear;
		logic  emit;
	} vfcm_cmd_t;

	typedef struct packed {
		func_t func;
		logic  in_range;
		logic  self_active;
		logic  clr_last;
	} vfcm_sts_t;

endpackage

### design/vfcm_ctrl.sv
// Controller state machine sequencing clear, begin, write and mesh operations.
module vfcm_ctrl
	import vfcm_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	output vfcm_cmd_t cmd,
	input  vfcm_sts_t sts
);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DISPATCH,
		ST_SELF,
		ST_NB,
		ST_EMIT
	} state_t;

	state_t state_q;
	rsel_t  sel_q;
	rsel_t  sel_next;

	always_comb begin
		unique case (sel_q)
			RS_DOWN: sel_next = RS_UP;
			RS_UP:   sel_next = RS_LEFT;
			RS_LEFT: sel_next = RS_RIGHT;
			default: sel_next = RS_DOWN;
		endcase
	end

	assign busy = (state_q != ST_IDLE);

	always_comb begin
		cmd = '0;
		cmd.rd_sel = RS_SELF;
		cmd.cap_sel = RS_SELF;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clr_en = 1'b1;
			end
			ST_IDLE: begin
				cmd.latch = start;
			end
			ST_DISPATCH: begin
				if (sts.func == FN_BEGIN) begin
					cmd.cnt_clear = 1'b1;
				end else if (sts.in_range &&
						(sts.func == FN_WRITE || sts.func == FN_MESH)) begin
					cmd.rd_en = 1'b1;
				end
			end
			ST_SELF: begin
				cmd.cap_en = 1'b1;
				if (sts.func == FN_WRITE) begin
					cmd.wr_en = 1'b1;
				end else if (sts.self_active) begin
					cmd.rd_en = 1'b1;
					cmd.rd_sel = RS_DOWN;
				end
			end
			ST_NB: begin
				cmd.cap_en = 1'b1;
				cmd.cap_sel = sel_q;
				if (sel_q != RS_RIGHT) begin
					cmd.rd_en = 1'b1;
					cmd.rd_sel = sel_next;
				end
			end
			ST_EMIT: begin
				cmd.emit = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			sel_q <= RS_DOWN;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					if (sts.clr_last) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (start) state_q <= ST_DISPATCH;
				end
				ST_DISPATCH: begin
					if (sts.func != FN_BEGIN && sts.in_range &&
							(sts.func == FN_WRITE || sts.func == FN_MESH)) begin
						state_q <= ST_SELF;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_SELF: begin
					if (sts.func == FN_MESH && sts.self_active) begin
						state_q <= ST_NB;
						sel_q <= RS_DOWN;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_NB: begin
					if (sel_q == RS_RIGHT) begin
						state_q <= ST_EMIT;
					end else begin
						sel_q <= sel_next;
					end
				end
				ST_EMIT: begin
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

### design/vfcm_datapath.sv
// Datapath: voxel memories, neighbor row registers, face mask and vertex counter.
module vfcm_datapath
	import vfcm_pkg::*;
#(
	parameter int GRID_SIDE = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  vfcm_cmd_t           cmd,
	output vfcm_sts_t           sts,
	input  logic [1:0]          func,
	input  logic [3:0]          vox_x,
	input  logic [3:0]          vox_y,
	input  logic [3:0]          vox_z,
	input  logic                solid,
	input  logic [KIND_W-1:0]   material,
	input  logic                cfg_wr_en,
	input  logic                cfg_wr_data,
	output logic                done,
	output logic [3:0]          out_x,
	output logic [3:0]          out_y,
	output logic [3:0]          out_z,
	output logic [FACE_N-1:0]   face_mask,
	output logic [COUNT_W-1:0]  face_count,
	output logic [VERTEX_W-1:0] first_vertex,
	output logic [KIND_W-1:0]   texture_layer
);

	localparam int CW = (GRID_SIDE > 1) ? $clog2(GRID_SIDE) : 1;
	localparam int ROW_W = 1 << CW;
	localparam int ROWS = 1 << (2 * CW);
	localparam int CELLS = 1 << (3 * CW);

	// Latched item
	func_t             func_q;
	logic [3:0]        x_q, y_q, z_q;
	logic              solid_q;
	logic [KIND_W-1:0] material_q;

	logic [CW-1:0] xc, yc, zc, zp, zm, top;
	logic          in_range;

	// Memories
	logic [ROW_W-1:0]  row_mem [ROWS];
	logic [KIND_W-1:0] kind_mem [CELLS];
	logic [ROW_W-1:0]  row_rd_q;
	logic [KIND_W-1:0] kind_rd_q;

	logic [CW-1:0]     xa, ya;
	logic [2*CW-1:0]   rd_addr, wr_addr;
	logic [ROW_W-1:0]  wr_row, new_row;
	logic [2*CW-1:0]   clr_q;

	// Captured rows
	logic [ROW_W-1:0]  self_row_q, down_row_q, up_row_q, left_row_q, right_row_q;
	logic [KIND_W-1:0] kind_q;

	logic                down_en_q;
	logic [VERTEX_W-1:0] total_q;
	logic [FACE_N-1:0]   mask;
	logic [COUNT_W-1:0]  count;
	logic [VERTEX_W:0]   sum;

	assign xc = CW'(x_q);
	assign yc = CW'(y_q);
	assign zc = CW'(z_q);
	assign zp = zc + CW'(1);
	assign zm = zc - CW'(1);
	assign top = CW'(GRID_SIDE - 1);
	assign in_range = (32'(x_q) < GRID_SIDE) && (32'(y_q) < GRID_SIDE) &&
		(32'(z_q) < GRID_SIDE);

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			func_q <= func_t'(func);
			x_q <= vox_x;
			y_q <= vox_y;
			z_q <= vox_z;
			solid_q <= solid;
			material_q <= material;
		end
	end

	// Neighbor row address; out-of-grid wraps are masked by the border tests
	always_comb begin
		xa = xc;
		ya = yc;
		case (cmd.rd_sel)
			RS_DOWN:  ya = yc - CW'(1);
			RS_UP:    ya = yc + CW'(1);
			RS_LEFT:  xa = xc - CW'(1);
			RS_RIGHT: xa = xc + CW'(1);
			default: ;
		endcase
	end
	assign rd_addr = {xa, ya};

	always_comb begin
		new_row = row_rd_q;
		new_row[zc] = solid_q;
	end

	assign wr_addr = cmd.clr_en ? clr_q : {xc, yc};
	assign wr_row = cmd.clr_en ? '0 : new_row;

	always_ff @(posedge clk) begin
		if (cmd.clr_en || cmd.wr_en) begin
			row_mem[wr_addr] <= wr_row;
		end
		if (cmd.rd_en) begin
			row_rd_q <= row_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			kind_mem[{xc, yc, zc}] <= material_q;
		end
		if (cmd.rd_en && cmd.rd_sel == RS_SELF) begin
			kind_rd_q <= kind_mem[{xc, yc, zc}];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clr_en) begin
			clr_q <= clr_q + (2*CW)'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap_en) begin
			case (cmd.cap_sel)
				RS_SELF: begin
					self_row_q <= row_rd_q;
					kind_q <= kind_rd_q;
				end
				RS_DOWN:  down_row_q <= row_rd_q;
				RS_UP:    up_row_q <= row_rd_q;
				RS_LEFT:  left_row_q <= row_rd_q;
				RS_RIGHT: right_row_q <= row_rd_q;
				default: ;
			endcase
		end
	end

	assign sts.func = func_q;
	assign sts.in_range = in_range;
	assign sts.self_active = row_rd_q[zc];
	assign sts.clr_last = &clr_q;

	// Face visibility: border or inactive neighbor; the down face also needs down_en_q
	always_comb begin
		mask = '0;
		mask[FACE_FRONT] = (zc == top) || !self_row_q[zp];
		mask[FACE_DOWN] = down_en_q && ((yc == '0) || !down_row_q[zc]);
		mask[FACE_BACK] = (zc == '0) || !self_row_q[zm];
		mask[FACE_UP] = (yc == top) || !up_row_q[zc];
		mask[FACE_LEFT] = (xc == '0) || !left_row_q[zc];
		mask[FACE_RIGHT] = (xc == top) || !right_row_q[zc];
	end

	assign count = COUNT_W'(mask[0]) + COUNT_W'(mask[1]) + COUNT_W'(mask[2]) +
		COUNT_W'(mask[3]) + COUNT_W'(mask[4]) + COUNT_W'(mask[5]);
	assign sum = {1'b0, total_q} + (VERTEX_W + 1)'({count, 2'b00});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			down_en_q <= 1'b0;
			total_q <= '0;
			done <= 1'b0;
		end else begin
			if (cfg_wr_en) down_en_q <= cfg_wr_data;
			if (cmd.cnt_clear) begin
				total_q <= '0;
			end else if (cmd.emit) begin
				total_q <= sum[VERTEX_W] ? '1 : sum[VERTEX_W-1:0];
			end
			done <= cmd.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_x <= x_q;
			out_y <= y_q;
			out_z <= z_q;
			face_mask <= mask;
			face_count <= count;
			first_vertex <= total_q;
			texture_layer <= kind_q - KIND_W'(1);
		end
	end

endmodule

### design/voxel_face_cull_mesher_unit.sv
// Top level of the voxel face-cull mesher: controller plus datapath.
//
// Channel   Direction  Handshake                      Payload
// item      in         start & !busy                  func, vox_x, vox_y, vox_z, solid, material
// result    out        done, one cycle, no backpress  out_x..texture_layer
// config    in         cfg_wr_en, every edge          cfg_wr_data (down face enable)
//
// States per item, from the transfer until idle: begin, unused code or coordinate
//   off the grid: dispatch; write: dispatch, self; mesh of an inactive voxel:
//   dispatch, self; mesh of an active voxel: dispatch, self, neighbor, emit, with
//   done registered from emit. The occupancy row memory has one read port, so the
//   self row and the four neighbor rows are read one per cycle.
// After reset the block sweeps all (2**clog2(GRID_SIDE))**2 occupancy rows
// (256 at the default) to zero, one row per cycle, with busy high.
// The receiver cannot stall: done is high for one cycle, and the result ports hold until the next result.
module voxel_face_cull_mesher_unit
	import vfcm_pkg::*;
#(
	parameter int GRID_SIDE = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [1:0]          func,
	input  logic [3:0]          vox_x,
	input  logic [3:0]          vox_y,
	input  logic [3:0]          vox_z,
	input  logic                solid,
	input  logic [KIND_W-1:0]   material,
	input  logic                cfg_wr_en,
	input  logic                cfg_wr_data,
	output logic                done,
	output logic [3:0]          out_x,
	output logic [3:0]          out_y,
	output logic [3:0]          out_z,
	output logic [FACE_N-1:0]   face_mask,
	output logic [COUNT_W-1:0]  face_count,
	output logic [VERTEX_W-1:0] first_vertex,
	output logic [KIND_W-1:0]   texture_layer
);

	// Commands flow from the controller, status flows back
	vfcm_cmd_t cmd;
	vfcm_sts_t sts;

	// Sequence clear pass, item decode, row reads and result emission
	vfcm_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.sts    (sts)
	);

	// Hold the grid, gather neighbor rows, build the mask and advance the counter
	vfcm_datapath #(
		.GRID_SIDE (GRID_SIDE)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.func          (func),
		.vox_x         (vox_x),
		.vox_y         (vox_y),
		.vox_z         (vox_z),
		.solid         (solid),
		.material      (material),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.done          (done),
		.out_x         (out_x),
		.out_y         (out_y),
		.out_z         (out_z),
		.face_mask     (face_mask),
		.face_count    (face_count),
		.first_vertex  (first_vertex),
		.texture_layer (texture_layer)
	);

endmodule
